// ----- rtl/sle_pkg.sv -----
package sle_pkg;

  typedef enum logic [2:0] {
    OP_INSERT  = 3'd0,
    OP_ERASE   = 3'd1,
    OP_POP_FRT = 3'd2,
    OP_POP_BCK = 3'd3,
    OP_REVERSE = 3'd4,
    OP_SEARCH  = 3'd5,
    OP_DUMP    = 3'd6,
    OP_CLEAR   = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  localparam int unsigned DataW  = 32;
  localparam int unsigned CountW = 6;

endpackage

// ----- rtl/sle_ram.sv -----
module sle_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/sorted_list_engine.sv -----
// Sorted list engine: an ordered list of up to CAPACITY signed 32-bit words.
// Input channel: in_valid/in_stall with in_op and in_value. Result channel:
// out_valid/out_stall with status, found, elem_value, last, count, is_empty.
// Each word is held in one RAM with a registered read port; a sequencer
// walks the list one entry per step, a read issued and returned each cycle.
// Every op gives one result word except dump of a non-empty list, which
// gives one word per entry with last set on the final one. Insert walks to
// the sorted position, then shifts the later entries up one at a time, a
// read and then a write per entry; erase walks to the match and shifts the
// later entries down; pop_front shifts every entry down; reverse swaps
// entries pairwise from both ends; search walks until a match; dump reads
// each entry in turn; pop_back and clear only change the fill count.
// Each result is held in an output register; the engine waits while the
// receiver asserts out_stall and resumes when it drops. in_stall is high
// from acceptance until the last result of the op is loaded into the
// output register.
// Reset (rst_n low, synchronous) empties the list; the RAM content is not
// cleared and its entries beyond the fill count are never used.
module sorted_list_engine #(
  parameter int unsigned CAPACITY = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_op,
  input  logic signed [31:0] in_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic        out_found,
  output logic signed [31:0] out_elem_value,
  output logic        out_last,
  output logic [5:0]  out_count,
  output logic        out_is_empty
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned FW = $clog2(CAPACITY + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_DISP, S_RDWAIT, S_WALK, S_SHRD, S_SHWR, S_RVA, S_RVB, S_RVW1,
    S_RVW2, S_DUMP, S_OUT
  } state_t;

  state_t state_r;
  logic [2:0] op_r;
  logic [31:0] val_r;
  logic [FW-1:0] fill_r;
  logic [FW-1:0] idx_r;
  logic [FW-1:0] hi_r;
  logic [31:0] tmp_r;
  logic [1:0] st_r;
  logic fnd_r;
  logic dir_r;

  logic we;
  logic [AW-1:0] waddr, raddr;
  logic [31:0] wdata, rdata;

  sle_ram #(.WIDTH(32), .DEPTH(CAPACITY)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr(raddr), .rdata(rdata)
  );

  // read address runs ahead: idx_r is the index whose data arrives next
  logic [FW-1:0] rd_idx;
  always_comb begin
    we = 1'b0;
    waddr = idx_r[AW-1:0];
    wdata = tmp_r;
    rd_idx = idx_r;
    unique case (state_r)
      S_DISP:   rd_idx = '0;
      S_WALK:   rd_idx = idx_r + FW'(1);
      S_SHRD:   rd_idx = dir_r ? idx_r - FW'(1) : idx_r + FW'(1);
      S_SHWR: begin
        we = 1'b1;
        wdata = (dir_r && idx_r == hi_r) ? val_r : rdata;
        rd_idx = idx_r;
      end
      S_RVA:    rd_idx = hi_r;
      S_RVW1: begin
        we = 1'b1; waddr = hi_r[AW-1:0]; wdata = rdata;
      end
      S_RVW2: begin
        we = 1'b1; waddr = idx_r[AW-1:0]; wdata = tmp_r;
      end
      default: ;
    endcase
    raddr = rd_idx[AW-1:0];
  end

  logic out_free;
  logic out_load;
  assign out_free = !out_valid || !out_stall;
  assign out_load = out_free && (state_r == S_DUMP || state_r == S_OUT);
  assign in_stall = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      fill_r <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            op_r <= in_op;
            val_r <= in_value;
            st_r <= sle_pkg::ST_OK;
            fnd_r <= 1'b0;
            idx_r <= '0;
            state_r <= S_DISP;
          end
        end
        S_DISP: begin
          unique case (sle_pkg::op_t'(op_r))
            sle_pkg::OP_INSERT: begin
              if (fill_r >= FW'(CAPACITY)) begin
                st_r <= sle_pkg::ST_FULL; state_r <= S_OUT;
              end else if (fill_r == '0) begin
                idx_r <= '0; hi_r <= '0; dir_r <= 1'b1; state_r <= S_SHWR;
              end else state_r <= S_RDWAIT;
            end
            sle_pkg::OP_ERASE, sle_pkg::OP_SEARCH, sle_pkg::OP_POP_FRT,
            sle_pkg::OP_DUMP: begin
              if (fill_r == '0) begin
                st_r <= sle_pkg::ST_EMPTY; state_r <= S_OUT;
              end else if (sle_pkg::op_t'(op_r) == sle_pkg::OP_POP_FRT) begin
                dir_r <= 1'b0; idx_r <= '0; state_r <= S_SHRD;
              end else state_r <= S_RDWAIT;
            end
            sle_pkg::OP_POP_BCK: begin
              if (fill_r == '0) st_r <= sle_pkg::ST_EMPTY;
              else fill_r <= fill_r - FW'(1);
              state_r <= S_OUT;
            end
            sle_pkg::OP_REVERSE: begin
              if (fill_r < FW'(2)) state_r <= S_OUT;
              else begin
                idx_r <= '0; hi_r <= fill_r - FW'(1); state_r <= S_RVA;
              end
            end
            default: begin
              fill_r <= '0; state_r <= S_OUT;
            end
          endcase
        end
        S_RDWAIT: state_r <= (sle_pkg::op_t'(op_r) == sle_pkg::OP_DUMP) ? S_DUMP : S_WALK;
        S_WALK: begin
          // rdata is entry idx_r
          if (sle_pkg::op_t'(op_r) == sle_pkg::OP_INSERT) begin
            if ((idx_r == '0 && $signed(val_r) < $signed(rdata)) ||
                (idx_r != '0 && !($signed(val_r) > $signed(rdata)))) begin
              hi_r <= idx_r; idx_r <= fill_r; dir_r <= 1'b1;
              state_r <= (idx_r == fill_r) ? S_SHWR : S_SHRD;
            end else if (idx_r + FW'(1) == fill_r) begin
              hi_r <= fill_r; idx_r <= fill_r; dir_r <= 1'b1; state_r <= S_SHWR;
            end else idx_r <= idx_r + FW'(1);
          end else if (rdata == val_r) begin
            if (sle_pkg::op_t'(op_r) == sle_pkg::OP_SEARCH) begin
              fnd_r <= 1'b1; state_r <= S_OUT;
            end else begin
              dir_r <= 1'b0; state_r <= S_SHRD;
            end
          end else if (idx_r + FW'(1) == fill_r) begin
            st_r <= sle_pkg::ST_NOTFOUND; state_r <= S_OUT;
          end else idx_r <= idx_r + FW'(1);
        end
        S_SHRD: begin
          // shift toward idx_r: read the neighbor, then write it here
          if (dir_r) begin
            if (idx_r == hi_r) state_r <= S_SHWR;
            else state_r <= S_SHWR;
          end else begin
            if (idx_r + FW'(1) >= fill_r) begin
              fill_r <= fill_r - FW'(1); state_r <= S_OUT;
            end else state_r <= S_SHWR;
          end
        end
        S_SHWR: begin
          if (dir_r) begin
            if (idx_r == hi_r) begin
              fill_r <= fill_r + FW'(1); state_r <= S_OUT;
            end else begin
              idx_r <= idx_r - FW'(1); state_r <= S_SHRD;
            end
          end else begin
            idx_r <= idx_r + FW'(1); state_r <= S_SHRD;
          end
        end
        S_RVA: state_r <= S_RVB;
        S_RVB: begin
          tmp_r <= rdata; state_r <= S_RVW1;
        end
        S_RVW1: state_r <= S_RVW2;
        S_RVW2: begin
          if (idx_r + FW'(1) >= hi_r - FW'(1) || idx_r + FW'(1) >= hi_r) begin
            if (idx_r + FW'(2) < hi_r) begin
              idx_r <= idx_r + FW'(1); hi_r <= hi_r - FW'(1); state_r <= S_RVA;
            end else state_r <= S_OUT;
          end else begin
            idx_r <= idx_r + FW'(1); hi_r <= hi_r - FW'(1); state_r <= S_RVA;
          end
        end
        S_DUMP: begin
          if (out_free) begin
            out_status <= sle_pkg::ST_OK;
            out_found <= 1'b0;
            out_elem_value <= rdata;
            out_last <= (idx_r + FW'(1) == fill_r);
            out_count <= 6'(fill_r);
            out_is_empty <= 1'b0;
            if (idx_r + FW'(1) == fill_r) state_r <= S_IDLE;
            else begin
              idx_r <= idx_r + FW'(1); state_r <= S_RDWAIT;
            end
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_status <= st_r;
            out_found <= fnd_r;
            out_elem_value <= '0;
            out_last <= 1'b1;
            out_count <= 6'(fill_r);
            out_is_empty <= (fill_r == '0);
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) fill_r <= FW'(CAPACITY))
    else $error("fill count above capacity");
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_found |-> out_status == sle_pkg::ST_OK)
    else $error("found without ok status");
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_empty |-> out_count == '0)
    else $error("empty flag with nonzero count");

endmodule
